FILE: rtl/pbd_pkg.sv
// shared types, constants and helpers for the pulse beat detector
// used by pbd_div and pulse_beat_detector_bpm; no dependencies
package pbd_pkg;

	// field widths
	localparam int SAMPLE_W = 12;
	localparam int TIME_W   = 32;
	localparam int IV_W     = 16;
	localparam int BPM_W    = 16;
	localparam int QUAL_W   = 7;
	localparam int RATIO_W  = 8;

	// history ring
	localparam int HISTORY_DEPTH = 8;
	localparam int HIST_IW       = $clog2(HISTORY_DEPTH);
	localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W         = IV_W + HIST_IW;

	// shared divider widths
	localparam int DIV_W    = SUM_W;
	localparam int DIVSOR_W = IV_W;
	localparam int DIV_CW   = $clog2(DIV_W);

	// detector constants
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 12'd4095;
	localparam logic [SAMPLE_W-1:0] THRESH_RESET = 12'd2048;
	localparam logic [SAMPLE_W:0]   HYSTERESIS   = 13'd50;
	localparam logic [BPM_W-1:0]    BPM_NUM      = 16'd60000;
	localparam logic [BPM_W-1:0]    BPM_LO       = 16'd40;
	localparam logic [BPM_W-1:0]    BPM_HI       = 16'd180;
	localparam logic [CNT_W-1:0]    MIN_BEATS    = CNT_W'(3);
	localparam logic [QUAL_W-1:0]   QUAL_OK      = 7'd50;

	// configuration port
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	typedef enum logic [2:0] {
		REG_DEBOUNCE = 3'd0,
		REG_MIN_IV   = 3'd1,
		REG_MAX_IV   = 3'd2,
		REG_BOUNDS   = 3'd3,
		REG_RATIO    = 3'd4
	} pbd_reg_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BOUNDS,
		ST_THRESH,
		ST_EDGE,
		ST_SUM,
		ST_DIV_MEAN,
		ST_WAIT_MEAN,
		ST_DIV_BPM,
		ST_WAIT_BPM,
		ST_OUT
	} pbd_state_t;

	// channel payloads
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [TIME_W-1:0]   time_ms;
	} pbd_in_t;

	typedef struct packed {
		logic                beat;
		logic [BPM_W-1:0]    bpm;
		logic                bpm_ok;
		logic [QUAL_W-1:0]   quality;
		logic                level_high;
		logic [SAMPLE_W-1:0] threshold;
		logic [SAMPLE_W-1:0] span;
	} pbd_out_t;

	// divider request and response
	typedef struct packed {
		logic                start;
		logic [DIV_W-1:0]    dividend;
		logic [DIVSOR_W-1:0] divisor;
	} pbd_div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} pbd_div_rsp_t;

	// quality code from span
	function automatic logic [QUAL_W-1:0] quality_of(input logic [SAMPLE_W-1:0] span);
		logic [QUAL_W-1:0] q;
		if (span < 12'd20)
			q = 7'd10;
		else if (span < 12'd50)
			q = 7'd30;
		else if (span < 12'd100)
			q = 7'd60;
		else
			q = 7'd85;
		return q;
	endfunction

endpackage

FILE: rtl/pulse_beat_detector_bpm.sv
// pulse beat detector: adaptive threshold, interval ring and bpm estimate
// each sample passes the bounds, threshold and edge states before the result register; one
// that gives a new bpm also takes a serial sum over the n stored intervals (n up to 8) and
// the shared 19-bit divider, once for the mean and, unless the mean is zero, for the bpm
// throughput: one sample at a time; sample stall stays high until the result is registered
// reset: asynchronous, active low; registers take their defaults, all tracking state cleared
module pulse_beat_detector_bpm
	import pbd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	// sample channel
	input  logic              smp_valid,
	output logic              smp_stall,
	input  pbd_in_t           smp,
	// result channel
	output logic              res_valid,
	input  logic              res_stall,
	output pbd_out_t          res
);

	// configuration registers
	logic [IV_W-1:0]    debounce_q;
	logic [IV_W-1:0]    min_iv_q;
	logic [IV_W-1:0]    max_iv_q;
	logic [IV_W-1:0]    bounds_period_q;
	logic [RATIO_W-1:0] ratio_q;
	logic               cfg_wr;
	pbd_reg_t           cfg_idx;

	// sequencer
	pbd_state_t state_q;
	pbd_state_t state_n;

	// latched sample
	logic [SAMPLE_W-1:0] sample_q;
	logic [TIME_W-1:0]   now_q;

	// tracking state
	logic [SAMPLE_W-1:0] min_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [SAMPLE_W-1:0] thresh_q;
	logic [TIME_W-1:0]   bounds_time_q;
	logic [TIME_W-1:0]   prev_beat_q;
	logic                have_prev_q;
	logic [TIME_W-1:0]   detect_time_q;
	logic [IV_W-1:0]     ring_q [HISTORY_DEPTH];
	logic [HIST_IW-1:0]  ring_pos_q;
	logic [CNT_W-1:0]    beat_cnt_q;
	logic [BPM_W-1:0]    bpm_q;
	logic                above_q;

	// per-sample working registers
	logic                deb_ok_q;
	logic [TIME_W-1:0]   iv_q;
	logic                iv_ok_q;
	logic                beat_q;
	logic [CNT_W-1:0]    sum_cnt_q;
	logic [SUM_W-1:0]    total_q;
	logic [IV_W-1:0]     mean_q;

	// result register
	pbd_out_t res_q;
	logic     res_valid_q;

	// combinational helpers
	logic                bounds_clr;
	logic [SAMPLE_W-1:0] min_base;
	logic [SAMPLE_W-1:0] max_base;
	logic [SAMPLE_W-1:0] min_new;
	logic [SAMPLE_W-1:0] max_new;
	logic [SAMPLE_W-1:0] thr_span;
	logic [SAMPLE_W+RATIO_W-1:0] thr_prod;
	logic                detect;
	logic                fall;
	logic [CNT_W-1:0]    beat_cnt_inc;
	logic                iv_store;
	logic [SAMPLE_W-1:0] span_now;
	logic [QUAL_W-1:0]   qual_now;
	logic                res_free;
	pbd_div_req_t        div_req;
	pbd_div_rsp_t        div_rsp;

	// ---------------- configuration port ----------------

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = pbd_reg_t'(paddr[APB_AW-1:2]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q      <= 16'd250;
			min_iv_q        <= 16'd300;
			max_iv_q        <= 16'd2000;
			bounds_period_q <= 16'd2000;
			ratio_q         <= 8'd153;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_DEBOUNCE: debounce_q      <= pwdata[IV_W-1:0];
				REG_MIN_IV:   min_iv_q        <= pwdata[IV_W-1:0];
				REG_MAX_IV:   max_iv_q        <= pwdata[IV_W-1:0];
				REG_BOUNDS:   bounds_period_q <= pwdata[IV_W-1:0];
				REG_RATIO:    ratio_q         <= pwdata[RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (cfg_idx)
			REG_DEBOUNCE: prdata = APB_DW'(debounce_q);
			REG_MIN_IV:   prdata = APB_DW'(min_iv_q);
			REG_MAX_IV:   prdata = APB_DW'(max_iv_q);
			REG_BOUNDS:   prdata = APB_DW'(bounds_period_q);
			REG_RATIO:    prdata = APB_DW'(ratio_q);
			default:      prdata = '0;
		endcase
	end

	// ---------------- sequencer ----------------

	assign res_free = !res_valid_q || !res_stall;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:      if (smp_valid) state_n = ST_BOUNDS;
			ST_BOUNDS:    state_n = ST_THRESH;
			ST_THRESH:    state_n = ST_EDGE;
			ST_EDGE:      state_n = (detect && iv_store && beat_cnt_inc >= MIN_BEATS) ?
			                        ST_SUM : ST_OUT;
			ST_SUM:       if (sum_cnt_q + 1'b1 == beat_cnt_q) state_n = ST_DIV_MEAN;
			ST_DIV_MEAN:  state_n = ST_WAIT_MEAN;
			ST_WAIT_MEAN: if (div_rsp.done) state_n = ST_DIV_BPM;
			ST_DIV_BPM:   state_n = (mean_q == '0) ? ST_OUT : ST_WAIT_BPM;
			ST_WAIT_BPM:  if (div_rsp.done) state_n = ST_OUT;
			ST_OUT:       if (res_free) state_n = ST_IDLE;
			default:      state_n = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		smp_stall        = (state_q != ST_IDLE);
		div_req.start    = 1'b0;
		div_req.dividend = total_q;
		div_req.divisor  = DIVSOR_W'(beat_cnt_q);
		case (state_q)
			ST_DIV_MEAN: div_req.start = 1'b1;
			ST_DIV_BPM: begin
				div_req.start    = (mean_q != '0);
				div_req.dividend = DIV_W'(BPM_NUM);
				div_req.divisor  = mean_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	// ---------------- datapath ----------------

	function automatic logic [TIME_W-1:0] smp_sub(input logic [TIME_W-1:0] a,
	                                              input logic [TIME_W-1:0] b);
		return a - b;
	endfunction

	// bounds window and running min/max
	always_comb begin
		bounds_clr = ((smp_sub(now_q, bounds_time_q)) > TIME_W'(bounds_period_q));
		min_base   = bounds_clr ? SAMPLE_MAX : min_q;
		max_base   = bounds_clr ? '0 : max_q;
		min_new    = (sample_q < min_base) ? sample_q : min_base;
		max_new    = (sample_q > max_base) ? sample_q : max_base;
	end

	// threshold as min plus ratio of span
	always_comb begin
		thr_span = max_q - min_q;
		thr_prod = thr_span * ratio_q;
	end

	// edge detection with hysteresis
	always_comb begin
		detect       = deb_ok_q && !above_q && (sample_q > thresh_q);
		fall         = deb_ok_q && above_q &&
		               (({1'b0, sample_q} + HYSTERESIS) < {1'b0, thresh_q});
		iv_store     = have_prev_q && iv_ok_q;
		beat_cnt_inc = (beat_cnt_q < CNT_W'(HISTORY_DEPTH)) ? beat_cnt_q + 1'b1 : beat_cnt_q;
	end

	// tracking and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q         <= SAMPLE_MAX;
			max_q         <= '0;
			thresh_q      <= THRESH_RESET;
			bounds_time_q <= '0;
			prev_beat_q   <= '0;
			have_prev_q   <= 1'b0;
			detect_time_q <= '0;
			ring_pos_q    <= '0;
			beat_cnt_q    <= '0;
			bpm_q         <= '0;
			above_q       <= 1'b0;
			beat_q        <= 1'b0;
			for (int i = 0; i < HISTORY_DEPTH; i++)
				ring_q[i] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (smp_valid)
						beat_q <= 1'b0;
				end
				ST_BOUNDS: begin
					min_q <= min_new;
					max_q <= max_new;
					if (bounds_clr)
						bounds_time_q <= now_q;
				end
				ST_THRESH: begin
					if (sample_q > min_q)
						thresh_q <= min_q + thr_prod[SAMPLE_W+RATIO_W-1:RATIO_W];
				end
				ST_EDGE: begin
					if (detect) begin
						above_q       <= 1'b1;
						prev_beat_q   <= now_q;
						have_prev_q   <= 1'b1;
						detect_time_q <= now_q;
						if (iv_store) begin
							ring_q[ring_pos_q] <= iv_q[IV_W-1:0];
							ring_pos_q <= (ring_pos_q == HIST_IW'(HISTORY_DEPTH - 1)) ?
							              '0 : ring_pos_q + 1'b1;
							beat_cnt_q <= beat_cnt_inc;
							if (beat_cnt_inc >= MIN_BEATS)
								beat_q <= 1'b1;
						end
					end else if (fall) begin
						above_q <= 1'b0;
					end
				end
				ST_DIV_BPM: begin
					if (mean_q == '0)
						bpm_q <= BPM_NUM;
				end
				ST_WAIT_BPM: begin
					if (div_rsp.done)
						bpm_q <= div_rsp.quotient[BPM_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// per-sample working values
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (smp_valid) begin
					sample_q <= smp.sample;
					now_q    <= smp.time_ms;
				end
			end
			ST_BOUNDS: begin
				deb_ok_q <= (smp_sub(now_q, detect_time_q) >= TIME_W'(debounce_q));
				iv_q     <= smp_sub(now_q, prev_beat_q);
				iv_ok_q  <= (smp_sub(now_q, prev_beat_q) >= TIME_W'(min_iv_q)) &&
				            (smp_sub(now_q, prev_beat_q) <= TIME_W'(max_iv_q));
			end
			ST_EDGE: begin
				sum_cnt_q <= '0;
				total_q   <= '0;
			end
			// serial sum over the stored intervals
			ST_SUM: begin
				total_q   <= total_q + SUM_W'(ring_q[sum_cnt_q[HIST_IW-1:0]]);
				sum_cnt_q <= sum_cnt_q + 1'b1;
			end
			ST_WAIT_MEAN: begin
				if (div_rsp.done)
					mean_q <= div_rsp.quotient[IV_W-1:0];
			end
			default: ;
		endcase
	end

	// shared divider for mean and bpm
	pbd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---------------- result register ----------------

	always_comb begin
		span_now = (max_q > min_q) ? (max_q - min_q) : '0;
		qual_now = quality_of(span_now);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (state_q == ST_OUT && res_free)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && res_free) begin
			res_q.beat       <= beat_q;
			res_q.bpm        <= bpm_q;
			res_q.bpm_ok     <= (bpm_q >= BPM_LO) && (bpm_q <= BPM_HI) &&
			                    (beat_cnt_q >= MIN_BEATS) && (qual_now >= QUAL_OK);
			res_q.quality    <= qual_now;
			res_q.level_high <= above_q;
			res_q.threshold  <= thresh_q;
			res_q.span       <= span_now;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

FILE: rtl/pbd_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on pbd_pkg for widths and the request/response structs
module pbd_div
	import pbd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  pbd_div_req_t req,
	output pbd_div_rsp_t rsp
);

	logic [DIV_W-1:0]    dq_q;
	logic [DIVSOR_W-1:0] rem_q;
	logic [DIVSOR_W-1:0] dvs_q;
	logic [DIV_CW-1:0]   cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [DIVSOR_W:0]   rem_sh;
	logic [DIVSOR_W:0]   rem_diff;
	logic                ge;

	// trial subtract of the shifted remainder
	always_comb begin
		rem_sh   = {rem_q, dq_q[DIV_W-1]};
		rem_diff = rem_sh - {1'b0, dvs_q};
		ge       = (rem_sh >= {1'b0, dvs_q});
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DIV_W-2:0], ge};
			rem_q <= ge ? rem_diff[DIVSOR_W-1:0] : rem_sh[DIVSOR_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;

endmodule

FILE: tb/sv/pulse_beat_detector_bpm_tb.sv
// testbench for pulse_beat_detector_bpm: directed samples, then pulse trains with noise,
// checked against a beat predictor kept in a small scoreboard class
// depends on pbd_pkg and the pulse_beat_detector_bpm rtl
module pulse_beat_detector_bpm_tb;
	import pbd_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int          SETTLE_CYCLES = 60;
	localparam int          HYST_MARGIN   = 50;
	localparam int unsigned BPM_SCALE     = 60000;
	localparam logic [2:0]  REG_UNUSED    = 3'd5;

	// predicts one result per sample and matches the results coming back
	class beat_scoreboard;
		logic [15:0] debounce, min_iv, max_iv, bounds_period;
		logic [7:0]  ratio;
		logic [11:0] trk_min, trk_max, thresh;
		logic [31:0] bounds_t, prev_beat_t, detect_t;
		logic        have_prev, above;
		logic [15:0] ring [HISTORY_DEPTH];
		logic [2:0]  wr_pos;
		logic [3:0]  n_iv;
		logic [15:0] bpm_last;
		pbd_out_t    expected_q[$];
		int          errors;
		int          reported;

		function new();
			debounce      = 16'd250;
			min_iv        = 16'd300;
			max_iv        = 16'd2000;
			bounds_period = 16'd2000;
			ratio         = 8'd153;
			trk_min       = 12'd4095;
			trk_max       = 12'd0;
			thresh        = 12'd2048;
			bounds_t      = '0;
			prev_beat_t   = '0;
			detect_t      = '0;
			have_prev     = 1'b0;
			above         = 1'b0;
			foreach (ring[i]) ring[i] = '0;
			wr_pos        = '0;
			n_iv          = '0;
			bpm_last      = '0;
			errors        = 0;
			reported      = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_DEBOUNCE: debounce      = value[15:0];
				REG_MIN_IV:   min_iv        = value[15:0];
				REG_MAX_IV:   max_iv        = value[15:0];
				REG_BOUNDS:   bounds_period = value[15:0];
				REG_RATIO:    ratio         = value[7:0];
				default: ;
			endcase
		endfunction

		function logic [6:0] quality_code(logic [11:0] sp);
			if (sp < 12'd20) return 7'd10;
			if (sp < 12'd50) return 7'd30;
			if (sp < 12'd100) return 7'd60;
			return 7'd85;
		endfunction

		// advance the detector by one sample and queue what it should report
		function void note_sample(pbd_in_t x);
			logic [31:0] elapsed;
			logic [31:0] iv;
			logic [19:0] scaled;
			logic [11:0] s;
			logic [11:0] sp;
			int unsigned total;
			int unsigned mean;
			pbd_out_t    e;
			s = x.sample;
			e = '0;
			// bounds window
			elapsed = x.time_ms - bounds_t;
			if (elapsed > {16'd0, bounds_period}) begin
				trk_min  = 12'd4095;
				trk_max  = 12'd0;
				bounds_t = x.time_ms;
			end
			if (s < trk_min) trk_min = s;
			if (s > trk_max) trk_max = s;
			// threshold moves only for samples above the minimum
			if (s > trk_min) begin
				scaled = 20'(trk_max - trk_min) * 20'(ratio);
				thresh = trk_min + scaled[19:8];
			end
			// edge detection outside the debounce window
			elapsed = x.time_ms - detect_t;
			if (elapsed >= {16'd0, debounce}) begin
				if (!above && s > thresh) begin
					above = 1'b1;
					if (have_prev) begin
						iv = x.time_ms - prev_beat_t;
						if (iv >= {16'd0, min_iv} && iv <= {16'd0, max_iv}) begin
							ring[wr_pos] = iv[15:0];
							wr_pos = wr_pos + 3'd1;
							if (n_iv < HISTORY_DEPTH) n_iv = n_iv + 4'd1;
							if (n_iv >= 4'd3) begin
								total = 0;
								for (int i = 0; i < HISTORY_DEPTH; i++)
									if (i < n_iv) total += ring[i];
								mean = total / n_iv;
								bpm_last = (mean == 0) ? 16'(BPM_SCALE) : 16'(BPM_SCALE / mean);
								e.beat = 1'b1;
							end
						end
					end
					prev_beat_t = x.time_ms;
					have_prev   = 1'b1;
					detect_t    = x.time_ms;
				end
				if (above && int'(s) + HYST_MARGIN < int'(thresh)) above = 1'b0;
			end
			sp           = (trk_max > trk_min) ? trk_max - trk_min : 12'd0;
			e.bpm        = bpm_last;
			e.quality    = quality_code(sp);
			e.bpm_ok     = (bpm_last >= 16'd40 && bpm_last <= 16'd180 && n_iv >= 4'd3 &&
				e.quality >= 7'd50);
			e.level_high = above;
			e.threshold  = thresh;
			e.span       = sp;
			expected_q.push_back(e);
		endfunction

		function void check_result(pbd_out_t got);
			pbd_out_t e;
			if (expected_q.size() == 0) begin
				errors++;
				if (reported < 10) begin
					$display("unexpected result: %p", got);
					reported++;
				end
				return;
			end
			e = expected_q.pop_front();
			if (got.beat !== e.beat || got.bpm !== e.bpm || got.bpm_ok !== e.bpm_ok ||
				got.quality !== e.quality || got.level_high !== e.level_high ||
				got.threshold !== e.threshold || got.span !== e.span) begin
				errors++;
				if (reported < 10) begin
					$display("result mismatch");
					$display("  expected beat=%0d bpm=%0d ok=%0d q=%0d lvl=%0d thr=%0d span=%0d",
						e.beat, e.bpm, e.bpm_ok, e.quality, e.level_high, e.threshold, e.span);
					$display("  actual   beat=%0d bpm=%0d ok=%0d q=%0d lvl=%0d thr=%0d span=%0d",
						got.beat, got.bpm, got.bpm_ok, got.quality, got.level_high,
						got.threshold, got.span);
					reported++;
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [APB_AW-1:0] paddr     = '0;
	logic [APB_DW-1:0] pwdata    = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              smp_valid = 1'b0;
	logic              smp_stall;
	pbd_in_t           smp       = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	pbd_out_t          res;

	beat_scoreboard sb;
	logic [31:0]    t_now       = '0;
	bit             idle_on     = 1'b1;
	int             stall_left  = 0;
	int unsigned    cycle_count = 0;

	pulse_beat_detector_bpm u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp       (smp),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result side: check each transfer and stall in random bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) sb.check_result(res);
			if (stall_left > 0) begin
				res_stall  <= 1'b1;
				stall_left <= stall_left - 1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				res_stall  <= 1'b1;
				stall_left <= $urandom_range(0, 3);
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// one sample transfer, with an optional gap in front
	task automatic send_sample(input pbd_in_t x);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			smp_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		smp       <= x;
		smp_valid <= 1'b1;
		@(posedge clk);
		while (smp_stall) @(posedge clk);
		sb.note_sample(x);
	endtask

	task automatic send_at(input logic [11:0] s, input logic [31:0] t);
		pbd_in_t x;
		x.sample  = s;
		x.time_ms = t;
		t_now     = t;
		send_sample(x);
	endtask

	// hold the sender until every result is back
	task automatic wait_results_done();
		smp_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write: setup cycle, then access cycle
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// upper data bits are random, only the register width counts
	task automatic set_config(input logic [15:0] d, input logic [15:0] mn, input logic [15:0] mx,
		input logic [15:0] b, input logic [7:0] r);
		wait_results_done();
		write_reg(REG_DEBOUNCE, {16'($urandom()), d});
		write_reg(REG_MIN_IV, {16'($urandom()), mn});
		write_reg(REG_MAX_IV, {16'($urandom()), mx});
		write_reg(REG_BOUNDS, {16'($urandom()), b});
		write_reg(REG_RATIO, {24'($urandom()), r});
	endtask

	// square-ish pulse wave with jitter, some samples replaced by noise or time jumps
	task automatic pulse_train(input int n, input int period, input int base, input int peak,
		input int step_max, input int noise_pct);
		int      lvl;
		int      phase;
		pbd_in_t x;
		for (int k = 0; k < n; k++) begin
			t_now = t_now + $urandom_range(0, step_max);
			if ($urandom_range(0, 99) < noise_pct) begin
				lvl = $urandom_range(0, 4095);
				if ($urandom_range(0, 3) == 0) t_now = $urandom();
			end else begin
				phase = int'(t_now % period);
				lvl = (phase < period / 5) ? peak : base;
				lvl = lvl + int'($urandom_range(0, 80)) - 40;
				if (lvl < 0) lvl = 0;
				if (lvl > 4095) lvl = 4095;
			end
			x.sample  = 12'(lvl);
			x.time_ms = t_now;
			send_sample(x);
		end
	endtask

	// stimulus
	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero intervals right after reset drive the mean to zero
		set_config(16'd0, 16'd0, 16'd2000, 16'd2000, 8'd128);
		for (int k = 0; k < 7; k++) send_at((k % 2 == 0) ? 12'd4095 : 12'd0, 32'd5);

		// back to defaults, plus a write to an unmapped register
		set_config(16'd250, 16'd300, 16'd2000, 16'd2000, 8'd153);
		write_reg(REG_UNUSED, 32'hffff_ffff);
		send_at(12'd0, 32'd100);      // inside debounce, sample at minimum
		send_at(12'd0, 32'd400);
		send_at(12'd4095, 32'd700);
		send_at(12'd4095, 32'd1000);
		send_at(12'd200, 32'd1300);
		send_at(12'd3000, 32'd1400);
		send_at(12'd100, 32'd1500);
		send_at(12'd100, 32'd1900);
		send_at(12'd3500, 32'd4500);  // bounds clear, interval too long
		send_at(12'd0, 32'hffff_ff00);
		send_at(12'd4095, 32'hffff_ffff);
		send_at(12'd0, 32'h0000_0100); // timestamp wrap
		send_at(12'd4095, 32'h0000_0300);

		// threshold at zero: level never falls
		set_config(16'd0, 16'd300, 16'd2000, 16'd2000, 8'd0);
		send_at(12'd30, 32'h0000_0400);
		send_at(12'd0, 32'h0000_0401);
		send_at(12'd4095, 32'h0000_0402);

		// default settings with regular pulses, one full pause in the middle
		set_config(16'd250, 16'd300, 16'd2000, 16'd2000, 8'd153);
		pulse_train(120, 800, 700, 3000, 60, 5);
		wait_results_done();
		pulse_train(120, 550, 1500, 2600, 40, 5);

		// upper extremes
		set_config(16'd0, 16'd0, 16'd65535, 16'd65535, 8'd255);
		pulse_train(100, 300, 200, 4000, 20, 10);

		// lower extremes and a huge debounce
		set_config(16'd65535, 16'd1, 16'd1, 16'd1, 8'd0);
		pulse_train(80, 700, 100, 3500, 60, 20);

		// random settings over the full register range
		for (int k = 0; k < 3; k++) begin
			set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				8'($urandom_range(0, 255)));
			pulse_train(60, $urandom_range(200, 2000), $urandom_range(0, 2000),
				$urandom_range(2000, 4095), $urandom_range(5, 300), 25);
		end

		// plausible settings, last part without idling
		set_config(16'd100, 16'd250, 16'd1800, 16'd3000, 8'd128);
		pulse_train(150, 650, 900, 3200, 50, 5);
		idle_on = 1'b0;
		pulse_train(200, 900, 400, 2200, 70, 5);

		wait_results_done();
		if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
